>>> hdl/sqsr_pkg.sv
// ----------------------------------------------------------------------------
// sqsr_pkg
// Shared types and constants for the shifting queue with swap and remove.
// ----------------------------------------------------------------------------
package sqsr_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int ENTRY_WIDTH_DEF = 32;

    localparam int MODE_W        = 2;
    localparam int ENTRY_FIELD_W = 32;
    localparam int INDEX_FIELD_W = 6;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 7;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENQUEUE = 2'd0,
        MODE_DEQUEUE = 2'd1,
        MODE_SWAP    = 2'd2,
        MODE_REMOVE  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BAD_POS  = 2'd3
    } status_t;

    // Per-cell control decoded once per command by the top level.
    typedef struct packed {
        logic load_in;  // take the incoming entry (tail append)
        logic shift;    // take the right-hand neighbor's entry
        logic take_a;   // take the entry read on bus A (swap)
        logic take_b;   // take the entry read on bus B (swap)
        logic sel_a;    // drive this cell's entry onto bus A
        logic sel_b;    // drive this cell's entry onto bus B
    } cell_ctl_t;

endpackage

>>> hdl/sqsr_cell.sv
// ----------------------------------------------------------------------------
// sqsr_cell
// One queue position: holds an entry and loads the new entry, its neighbor's
// entry or a swap partner as its control says.
// ----------------------------------------------------------------------------
module sqsr_cell #(
    parameter int ENTRY_WIDTH = sqsr_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                   aclk,
    input  sqsr_pkg::cell_ctl_t    ctl,
    input  logic [ENTRY_WIDTH-1:0] entry_val,
    input  logic [ENTRY_WIDTH-1:0] next_val,
    input  logic [ENTRY_WIDTH-1:0] bus_a,
    input  logic [ENTRY_WIDTH-1:0] bus_b,
    output logic [ENTRY_WIDTH-1:0] q,
    output logic [ENTRY_WIDTH-1:0] rd_a,
    output logic [ENTRY_WIDTH-1:0] rd_b
);
    import sqsr_pkg::*;

    logic [ENTRY_WIDTH-1:0] val_reg;
    logic [ENTRY_WIDTH-1:0] val_next;

    always_comb begin
        val_next = val_reg;
        if (ctl.load_in) begin
            val_next = entry_val;
        end else if (ctl.shift) begin
            val_next = next_val;
        end else if (ctl.take_a) begin
            val_next = bus_a;
        end else if (ctl.take_b) begin
            val_next = bus_b;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign q    = val_reg;
    assign rd_a = ctl.sel_a ? val_reg : '0;
    assign rd_b = ctl.sel_b ? val_reg : '0;

endmodule

>>> hdl/shifting_queue_with_swap_remove.sv
// ----------------------------------------------------------------------------
// shifting_queue_with_swap_remove
// Bounded ordered queue held in a row of register cells, with enqueue,
// dequeue, swap of two positions and remove at a position.
// ----------------------------------------------------------------------------
// Usage:
// Each command beat on the s_ channel carries a mode, an entry handle and two
// positions. Every accepted command yields exactly one result beat on the m_
// channel with the dequeued entry, a status, the count after the command and
// the empty and full flags. A refused command leaves the queue unchanged.
// The result is registered and appears the cycle after the command beat. One
// command is taken per cycle unless a result is stalled. All cells update in the
// same cycle, each loading its right neighbor, the new entry or a swap partner
// read on the two read buses, so the decode and the read buses set the cycle.
// The result sits in an output register. While it waits for m_tready, the
// next command is held off; once it is taken, a new command is accepted in the
// same cycle.
// Reset empties the queue and drops any pending result. Entry contents are not
// cleared; only valid positions are ever read.
// ----------------------------------------------------------------------------
module shifting_queue_with_swap_remove #(
    parameter int CAPACITY    = sqsr_pkg::CAPACITY_DEF,
    parameter int ENTRY_WIDTH = sqsr_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mode[1:0], entry_in[33:2], index_a[39:34], index_b[45:40], zero[47:46]
    input  logic [sqsr_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // entry_out[31:0], status[33:32], count[40:34], is_empty[41], is_full[42],
    // zero[47:43]
    output logic [sqsr_pkg::M_TDATA_W-1:0] m_tdata
);
    import sqsr_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > INDEX_FIELD_W) ? CNT_W : INDEX_FIELD_W;
    localparam int EXT_W  = (ENTRY_WIDTH > ENTRY_FIELD_W) ? ENTRY_WIDTH : ENTRY_FIELD_W;
    localparam int CNTO_W = (CNT_W > COUNT_FIELD_W) ? CNT_W : COUNT_FIELD_W;

    mode_t                    mode;
    logic [ENTRY_FIELD_W-1:0] entry_in;
    logic [INDEX_FIELD_W-1:0] index_a;
    logic [INDEX_FIELD_W-1:0] index_b;

    logic [EXT_W-1:0]       in_wide;
    logic [ENTRY_WIDTH-1:0] entry_val;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] ia_x;
    logic [CMP_W-1:0] ib_x;

    logic    accept;
    logic    is_full_now;
    logic    is_empty_now;
    status_t status;
    logic    go;

    cell_ctl_t              ctl [CAPACITY];
    logic [ENTRY_WIDTH-1:0] q    [CAPACITY];
    logic [ENTRY_WIDTH-1:0] rd_a [CAPACITY];
    logic [ENTRY_WIDTH-1:0] rd_b [CAPACITY];
    logic [ENTRY_WIDTH-1:0] bus_a;
    logic [ENTRY_WIDTH-1:0] bus_b;

    logic [EXT_W-1:0]         head_wide;
    logic [ENTRY_FIELD_W-1:0] head_out;
    logic [CNTO_W-1:0]        count_wide;

    logic                     m_tvalid_reg;
    logic [ENTRY_FIELD_W-1:0] entry_out_reg;
    status_t                  status_reg;
    logic [COUNT_FIELD_W-1:0] count_out_reg;
    logic                     is_empty_reg;
    logic                     is_full_reg;

    assign mode     = mode_t'(s_tdata[1:0]);
    assign entry_in = s_tdata[33:2];
    assign index_a  = s_tdata[39:34];
    assign index_b  = s_tdata[45:40];

    assign in_wide   = EXT_W'(entry_in);
    assign entry_val = in_wide[ENTRY_WIDTH-1:0];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign cnt_x = CMP_W'(count_reg);
    assign ia_x  = CMP_W'(index_a);
    assign ib_x  = CMP_W'(index_b);

    assign is_full_now  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty_now = (count_reg == '0);

    always_comb begin
        unique case (mode)
            MODE_ENQUEUE: status = is_full_now ? ST_FULL : ST_DONE;
            MODE_DEQUEUE: status = is_empty_now ? ST_EMPTY : ST_DONE;
            MODE_SWAP: begin
                status = ((ia_x >= cnt_x) || (ib_x >= cnt_x) || (ia_x == ib_x))
                         ? ST_BAD_POS : ST_DONE;
            end
            MODE_REMOVE: status = (ia_x >= cnt_x) ? ST_BAD_POS : ST_DONE;
            default: status = ST_BAD_POS;
        endcase
    end

    assign go = accept && (status == ST_DONE);

    always_comb begin
        count_next = count_reg;
        if (go) begin
            if (mode == MODE_ENQUEUE) begin
                count_next = count_reg + CNT_W'(1);
            end else if ((mode == MODE_DEQUEUE) || (mode == MODE_REMOVE)) begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ctl[i].load_in = go && (mode == MODE_ENQUEUE) && (cnt_x == CMP_W'(i));
            ctl[i].shift   = go && ((mode == MODE_DEQUEUE) ||
                                    ((mode == MODE_REMOVE) && (ia_x <= CMP_W'(i))));
            ctl[i].take_a  = go && (mode == MODE_SWAP) && (ib_x == CMP_W'(i));
            ctl[i].take_b  = go && (mode == MODE_SWAP) && (ia_x == CMP_W'(i));
            ctl[i].sel_a   = (ia_x == CMP_W'(i));
            ctl[i].sel_b   = (ib_x == CMP_W'(i));
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ENTRY_WIDTH-1:0] next_val;
        if (i == CAPACITY - 1) begin : g_last
            assign next_val = '0;
        end else begin : g_mid
            assign next_val = q[i + 1];
        end

        sqsr_cell #(
            .ENTRY_WIDTH(ENTRY_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl[i]),
            .entry_val (entry_val),
            .next_val  (next_val),
            .bus_a     (bus_a),
            .bus_b     (bus_b),
            .q         (q[i]),
            .rd_a      (rd_a[i]),
            .rd_b      (rd_b[i])
        );
    end

    always_comb begin
        bus_a = '0;
        bus_b = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            bus_a = bus_a | rd_a[i];
            bus_b = bus_b | rd_b[i];
        end
    end

    assign head_wide  = EXT_W'(q[0]);
    assign head_out   = head_wide[ENTRY_FIELD_W-1:0];
    assign count_wide = CNTO_W'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            entry_out_reg <= (go && (mode == MODE_DEQUEUE)) ? head_out : '0;
            status_reg    <= status;
            count_out_reg <= count_wide[COUNT_FIELD_W-1:0];
            is_empty_reg  <= (count_next == '0);
            is_full_reg   <= (count_next == CNT_W'(CAPACITY));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, is_full_reg, is_empty_reg, count_out_reg, status_reg,
                       entry_out_reg};

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(is_full_reg && is_empty_reg))
        else $error("Result reports full and empty at once.");

    a_refused_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (status != ST_DONE)) |=> (count_reg == $past(count_reg)))
        else $error("Refused command changed the entry count.");

    a_entry_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (entry_out_reg != '0)) |-> (status_reg == ST_DONE))
        else $error("Refused command returned a nonzero entry.");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_tdata)))
        else $error("Pending result changed while stalled.");
`endif

endmodule

>>> sim/tb_shifting_queue_with_swap_remove.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shifting_queue_with_swap_remove
// Drives enqueue, dequeue, swap and remove commands into the queue, predicts
// every result beat with a shadow copy of the queue and compares each field.
// Runs a directed part, random parts under several idling patterns and a
// back-pressure part that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_shifting_queue_with_swap_remove;
    import sqsr_pkg::*;

    localparam int QUEUE_DEPTH  = CAPACITY_DEF;
    localparam int HANDLE_W     = ENTRY_WIDTH_DEF;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        mode_t                    mode;
        logic [ENTRY_FIELD_W-1:0] handle;
        logic [INDEX_FIELD_W-1:0] pos_a;
        logic [INDEX_FIELD_W-1:0] pos_b;
    } queue_cmd_t;

    typedef struct {
        logic [ENTRY_FIELD_W-1:0] head;
        status_t                  status;
        logic [COUNT_FIELD_W-1:0] count;
        logic                     empty;
        logic                     full;
    } queue_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [HANDLE_W-1:0] shadow_entries [QUEUE_DEPTH];
    int                  shadow_count;
    queue_result_t       pending_results [$];
    int                  error_count;
    int                  cycle_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_left;
    bit                  growing;

    shifting_queue_with_swap_remove #(
        .CAPACITY   (QUEUE_DEPTH),
        .ENTRY_WIDTH(HANDLE_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL shifting_queue_with_swap_remove");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d",
                 what, got, want, cycle_count);
    endtask

    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", m_tdata[31:0], 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.head)
                    report_mismatch("entry_out", m_tdata[31:0], want.head);
                if (m_tdata[33:32] !== want.status)
                    report_mismatch("status", 32'(m_tdata[33:32]), 32'(want.status));
                if (m_tdata[40:34] !== want.count)
                    report_mismatch("count", 32'(m_tdata[40:34]), 32'(want.count));
                if (m_tdata[41] !== want.empty)
                    report_mismatch("is_empty", 32'(m_tdata[41]), 32'(want.empty));
                if (m_tdata[42] !== want.full)
                    report_mismatch("is_full", 32'(m_tdata[42]), 32'(want.full));
            end
        end
    end

    function automatic void close_gap_at(input int pos);
        for (int i = pos; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i + 1];
        shadow_count--;
    endfunction

    function automatic queue_result_t apply_command(input queue_cmd_t c);
        queue_result_t r;
        logic [HANDLE_W-1:0] tmp;
        r.head   = '0;
        r.status = ST_DONE;
        case (c.mode)
            MODE_ENQUEUE: begin
                if (shadow_count >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_entries[shadow_count] = c.handle[HANDLE_W-1:0];
                    shadow_count++;
                end
            end
            MODE_DEQUEUE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.head = ENTRY_FIELD_W'(shadow_entries[0]);
                    close_gap_at(0);
                end
            end
            MODE_SWAP: begin
                if (c.pos_a >= shadow_count || c.pos_b >= shadow_count
                        || c.pos_a == c.pos_b) begin
                    r.status = ST_BAD_POS;
                end else begin
                    tmp = shadow_entries[c.pos_a];
                    shadow_entries[c.pos_a] = shadow_entries[c.pos_b];
                    shadow_entries[c.pos_b] = tmp;
                end
            end
            default: begin
                if (c.pos_a >= shadow_count)
                    r.status = ST_BAD_POS;
                else
                    close_gap_at(c.pos_a);
            end
        endcase
        r.count = COUNT_FIELD_W'(shadow_count);
        r.empty = (shadow_count == 0);
        r.full  = (shadow_count == QUEUE_DEPTH);
        return r;
    endfunction

    function automatic queue_cmd_t make_cmd(input mode_t mode, input logic [31:0] handle,
                                            input int pos_a, input int pos_b);
        queue_cmd_t c;
        c.mode   = mode;
        c.handle = handle;
        c.pos_a  = pos_a[INDEX_FIELD_W-1:0];
        c.pos_b  = pos_b[INDEX_FIELD_W-1:0];
        return c;
    endfunction

    function automatic int pick_position();
        if (shadow_count > 0 && $urandom_range(3) != 0)
            return $urandom_range(shadow_count - 1);
        return $urandom_range(63);
    endfunction

    function automatic queue_cmd_t make_random_cmd();
        queue_cmd_t c;
        int roll;
        roll     = $urandom_range(99);
        c.handle = $urandom;
        c.pos_a  = INDEX_FIELD_W'(pick_position());
        c.pos_b  = ($urandom_range(9) == 0) ? c.pos_a : INDEX_FIELD_W'(pick_position());
        if (growing)
            c.mode = (roll < 80) ? MODE_ENQUEUE : mode_t'($urandom_range(3, 1));
        else
            c.mode = (roll < 10) ? MODE_ENQUEUE : mode_t'($urandom_range(3, 1));
        return c;
    endfunction

    task automatic send_command(input queue_cmd_t c);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, c.pos_b, c.pos_a, c.handle, c.mode};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_command(c));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_random_items(input int n, input int s_pct, input int r_pct);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < n; i++) begin
            send_command(make_random_cmd());
            if (shadow_count == QUEUE_DEPTH && $urandom_range(3) == 0)
                growing = 1'b0;
            if (shadow_count == 0 && $urandom_range(2) == 0)
                growing = 1'b1;
        end
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_command(make_cmd(MODE_DEQUEUE, 32'h1234_5678, 0, 0));
        send_command(make_cmd(MODE_REMOVE, 32'h0, 0, 0));
        send_command(make_cmd(MODE_SWAP, 32'h0, 0, 1));
        send_command(make_cmd(MODE_ENQUEUE, 32'h0000_0000, 63, 63));
        send_command(make_cmd(MODE_ENQUEUE, 32'hFFFF_FFFF, 0, 0));
        send_command(make_cmd(MODE_ENQUEUE, 32'hA5A5_A5A5, 21, 42));
        send_command(make_cmd(MODE_ENQUEUE, 32'h5A5A_5A5A, 42, 21));
        send_command(make_cmd(MODE_SWAP, 32'hFFFF_FFFF, 0, 3));
        send_command(make_cmd(MODE_SWAP, 32'h0, 2, 2));
        send_command(make_cmd(MODE_SWAP, 32'h0, 0, 63));
        send_command(make_cmd(MODE_SWAP, 32'h0, 63, 1));
        send_command(make_cmd(MODE_SWAP, 32'h0, 4, 0));
        send_command(make_cmd(MODE_REMOVE, 32'h0, 63, 0));
        send_command(make_cmd(MODE_REMOVE, 32'h0, 4, 0));
        send_command(make_cmd(MODE_REMOVE, 32'h0, 1, 0));
        send_command(make_cmd(MODE_REMOVE, 32'h0, 2, 63));
        send_command(make_cmd(MODE_DEQUEUE, 32'h0, 0, 0));
        send_command(make_cmd(MODE_DEQUEUE, 32'hFFFF_FFFF, 63, 63));
        send_command(make_cmd(MODE_DEQUEUE, 32'h0, 0, 0));
        send_command(make_cmd(MODE_REMOVE, 32'h0, 0, 0));
    endtask

    task automatic test_random_no_idle();
        run_random_items(150, 0, 0);
    endtask

    task automatic test_random_sender_idle();
        run_random_items(150, 53, 0);
    endtask

    task automatic test_random_receiver_stall();
        run_random_items(150, 0, 53);
    endtask

    task automatic test_random_both_idle();
        run_random_items(150, 27, 27);
    endtask

    // The receiver holds off while the sender keeps a beat on offer, so the
    // output register fills and the input stalls until the hold ends.
    task automatic test_backpressure_fill();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        hold_left = HOLD_CYCLES;
        @(posedge aclk);
        run_random_items(30, 0, 0);
    endtask

    task automatic test_drain_pause();
        run_random_items(12, 0, 20);
        wait_drained();
        run_random_items(12, 0, 20);
    endtask

    initial begin
        shadow_count  = 0;
        error_count   = 0;
        cycle_count   = 0;
        hold_left     = 0;
        growing       = 1'b1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure_fill();
        test_drain_pause();
        wait_drained();
        if (pending_results.size() != 0)
            report_mismatch("results missing", 0, pending_results.size());
        if (error_count == 0) begin
            $display("PASS shifting_queue_with_swap_remove");
        end else begin
            $display("FAIL shifting_queue_with_swap_remove");
        end
        $finish;
    end
endmodule

>>> sim.f
hdl/sqsr_pkg.sv
hdl/sqsr_cell.sv
hdl/shifting_queue_with_swap_remove.sv
sim/tb_shifting_queue_with_swap_remove.sv
